// ----- rtl/llq_pkg.sv -----
// Shared types and constants for the linked list queue manager.
`default_nettype none

package llq_pkg;

    localparam int N_SLOTS = 64;
    localparam int ID_W    = $clog2(N_SLOTS);
    localparam int CNT_W   = $clog2(N_SLOTS + 1);

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LINKED     = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_MEMBER = 2'd3
    } t_status;

    // one write per cycle into each link table
    typedef struct packed {
        logic nxt_we;
        t_id  nxt_addr;
        t_id  nxt_data;
        logic prv_we;
        t_id  prv_addr;
        t_id  prv_data;
    } t_link_wr;

endpackage

`default_nettype wire

// ----- rtl/linked_list_queue_manager_core.sv -----
// Top level of the circular doubly linked queue manager.
// An accepted transaction is registered alongside its link table reads, then evaluated, and its
// outcome is captured in the result register, which drives the result strobe.
// Throughput: one transaction per cycle; o_busy stays low.
// Reset: synchronous active low; clears linked marks, head, tail, count and the strobes.
// Link table contents are not reset. The receiver cannot stall results.
`default_nettype none

module linked_list_queue_manager_core
    import llq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_req_type,
    input  wire logic [5:0] i_elem_id,
    output logic            o_busy,
    output logic            o_valid,
    output logic [1:0]      o_status,
    output logic [6:0]      o_q_len,
    output logic [5:0]      o_head_id,
    output logic            o_is_empty
);

    logic     r_vld;
    logic     r_req;
    t_id      r_id;
    t_id      nxt_rd;
    t_id      prv_rd;
    t_link_wr link_wr;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= i_req_type;
        r_id  <= i_elem_id;
    end

    llq_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rd_addr (i_elem_id),
        .i_wr      (link_wr),
        .o_nxt_rd  (nxt_rd),
        .o_prv_rd  (prv_rd)
    );

    llq_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_vld),
        .i_req        (r_req),
        .i_id         (r_id),
        .i_nxt_rd     (nxt_rd),
        .i_prv_rd     (prv_rd),
        .o_wr         (link_wr),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_q_len      (o_q_len),
        .o_head_id    (o_head_id),
        .o_is_empty   (o_is_empty)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_valid)
        else $error("result strobe missing two cycles after accept");

    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_q_len <= CNT_W'(N_SLOTS)))
        else $error("queue size beyond slot count");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_head_id == '0 && o_q_len == '0))
        else $error("empty queue reports head or size");

    a_refused_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid) && o_status != ST_OK) |->
            (o_q_len == $past(o_q_len)))
        else $error("refused transaction changed queue size");
`endif

endmodule

`default_nettype wire

// ----- rtl/llq_link_mem.sv -----
// Next and previous link tables with registered reads and write bypass.
`default_nettype none

module llq_link_mem
    import llq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_id      i_rd_addr,
    input  wire t_link_wr i_wr,
    output t_id           o_nxt_rd,
    output t_id           o_prv_rd
);

    t_id  r_next_mem [N_SLOTS];
    t_id  r_prev_mem [N_SLOTS];
    t_id  r_nxt_raw;
    t_id  r_prv_raw;
    logic r_nxt_byp;
    logic r_prv_byp;
    t_id  r_nxt_bdat;
    t_id  r_prv_bdat;

    always_ff @(posedge i_clk) begin
        if (i_wr.nxt_we) begin
            r_next_mem[i_wr.nxt_addr] <= i_wr.nxt_data;
        end
        r_nxt_raw  <= r_next_mem[i_rd_addr];
        r_nxt_byp  <= i_wr.nxt_we && (i_wr.nxt_addr == i_rd_addr);
        r_nxt_bdat <= i_wr.nxt_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.prv_we) begin
            r_prev_mem[i_wr.prv_addr] <= i_wr.prv_data;
        end
        r_prv_raw  <= r_prev_mem[i_rd_addr];
        r_prv_byp  <= i_wr.prv_we && (i_wr.prv_addr == i_rd_addr);
        r_prv_bdat <= i_wr.prv_data;
    end

    assign o_nxt_rd = r_nxt_byp ? r_nxt_bdat : r_nxt_raw;
    assign o_prv_rd = r_prv_byp ? r_prv_bdat : r_prv_raw;

endmodule

`default_nettype wire

// ----- rtl/llq_update.sv -----
// Queue state registers, request evaluation and result register.
`default_nettype none

module llq_update
    import llq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_vld,
    input  wire logic     i_req,
    input  wire t_id      i_id,
    input  wire t_id      i_nxt_rd,
    input  wire t_id      i_prv_rd,
    output t_link_wr      o_wr,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output t_cnt          o_q_len,
    output t_id           o_head_id,
    output logic          o_is_empty
);

    // tail is kept explicitly; next(tail) and prev(head) are implied
    logic [N_SLOTS-1:0] r_mark, n_mark;
    t_id                r_head, n_head;
    t_id                r_tail, n_tail;
    t_cnt               r_cnt,  n_cnt;
    t_status            st;
    t_id                p_id;
    t_id                n_id;
    logic               is_head;
    logic               is_tail;

    always_comb begin
        n_mark  = r_mark;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        st      = ST_OK;
        o_wr    = '0;
        is_head = (i_id == r_head);
        is_tail = (i_id == r_tail);
        p_id    = is_head ? r_tail : i_prv_rd;
        n_id    = is_tail ? r_head : i_nxt_rd;
        if (i_vld) begin
            if (i_req == REQ_APPEND) begin
                if (r_mark[i_id]) begin
                    st = ST_LINKED;
                end else begin
                    if (r_cnt == '0) begin
                        n_head = i_id;
                    end else begin
                        o_wr.nxt_we   = 1'b1;
                        o_wr.nxt_addr = r_tail;
                        o_wr.nxt_data = i_id;
                        o_wr.prv_we   = 1'b1;
                        o_wr.prv_addr = i_id;
                        o_wr.prv_data = r_tail;
                    end
                    n_tail         = i_id;
                    n_mark[i_id]   = 1'b1;
                    n_cnt          = r_cnt + 1'b1;
                end
            end else begin
                if (r_cnt == '0) begin
                    st = ST_EMPTY;
                end else if (!r_mark[i_id]) begin
                    st = ST_NOT_MEMBER;
                end else begin
                    if (r_cnt == CNT_W'(1)) begin
                        n_head = '0;
                    end else begin
                        o_wr.nxt_we   = !is_tail;
                        o_wr.nxt_addr = p_id;
                        o_wr.nxt_data = n_id;
                        o_wr.prv_we   = !is_head;
                        o_wr.prv_addr = n_id;
                        o_wr.prv_data = p_id;
                        if (is_head) begin
                            n_head = n_id;
                        end
                        if (is_tail) begin
                            n_tail = p_id;
                        end
                    end
                    n_mark[i_id] = 1'b0;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_mark  <= n_mark;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            o_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_status   <= st;
        o_q_len    <= n_cnt;
        o_head_id  <= (n_cnt == '0) ? '0 : n_head;
        o_is_empty <= (n_cnt == '0);
    end

endmodule

`default_nettype wire
